// ===== hdl/ssnf_pkg.sv =====
// Shared types, constants and the digit glyph table for the seven-segment
// number formatter. No dependencies; every other file imports this package.
package ssnf_pkg;

    localparam int MAX_DISPLAYS_DEF    = 8;
    localparam int FRACTION_DIGITS_DEF = 7;

    localparam int VALUE_W      = 50;
    localparam int VALUE_BYTES  = (VALUE_W + 7) / 8;
    localparam int BCD_DIGITS   = 16;
    localparam int COUNT_W      = 4;
    localparam int PATTERNS_W   = 64;
    localparam int MASK_W       = 8;
    localparam int OUT_DATA_W   = PATTERNS_W + MASK_W;

    localparam logic [COUNT_W-1:0] DISPLAY_COUNT_RESET = 4'd4;

    localparam logic [7:0] SEG_DP = 8'd128;
    localparam logic [7:0] SEG_E  = 8'd121;
    localparam logic [7:0] SEG_R  = 8'd80;

    localparam logic MODE_SHOW  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef logic [3:0] bcd_digit_t;
    typedef logic [BCD_DIGITS-1:0][3:0] bcd_word_t;
    typedef logic [7:0] pattern_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_APPLY,
        ST_OUT
    } ssnf_state_t;

    // Lit-segment pattern (HGFEDCBA) of one decimal digit.
    function automatic pattern_t glyph(input bcd_digit_t d);
        pattern_t p;
        unique case (d)
            4'd0:    p = 8'd63;
            4'd1:    p = 8'd6;
            4'd2:    p = 8'd91;
            4'd3:    p = 8'd79;
            4'd4:    p = 8'd102;
            4'd5:    p = 8'd109;
            4'd6:    p = 8'd125;
            4'd7:    p = 8'd7;
            4'd8:    p = 8'd127;
            4'd9:    p = 8'd111;
            default: p = 8'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/ssnf_bcd_conv.sv =====
// Shift-and-add-3 binary to BCD converter, one input bit per clock.
// Depends on ssnf_pkg for the value width and the BCD word type.
module ssnf_bcd_conv (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [ssnf_pkg::VALUE_W-1:0]    bin,
    output logic                            done,
    output ssnf_pkg::bcd_word_t             bcd
);
    import ssnf_pkg::*;

    localparam int CNT_W = $clog2(VALUE_W);

    logic [VALUE_W-1:0] shift_reg, shift_next;
    bcd_word_t          bcd_reg, bcd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    bcd_word_t          adjusted;
    logic [4*BCD_DIGITS-1:0] adjusted_bits;

    always_comb
    begin
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            adjusted[k] = (bcd_reg[k] >= 4'd5) ? bcd_reg[k] + 4'd3 : bcd_reg[k];
        end
    end

    assign adjusted_bits = adjusted;

    always_comb
    begin
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            shift_next = bin;
            bcd_next   = '0;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next   = {adjusted_bits[4*BCD_DIGITS-2:0], shift_reg[VALUE_W-1]};
            shift_next = {shift_reg[VALUE_W-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// ===== hdl/seven_segment_number_formatter.sv =====
// Top level of the seven-segment number formatter: sequencer, digit store
// and output register. Depends on ssnf_pkg and ssnf_bcd_conv.
//
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+--------------------------------------
// s_*      | in        | s_tvalid / s_tready  | tdata: value; tuser: mode
// m_*      | out       | m_tvalid / m_tready  | tdata: patterns, mask; tuser: overflow
// cfg_*    | in        | cfg_valid / cfg_ready| data: display_count
//
// A show transaction passes through the bit-serial BCD converter (one value bit per
// clock), then the converter's done flag, one step to find the integer digit count and
// one to rewrite the digit store before m_tvalid rises. A clear transaction skips the
// converter and goes straight to the store rewrite.
// The block takes one transaction at a time; s_tready is high only when no
// transaction is in flight and the previous result has been taken, so a stalled
// m_tready holds the block. Reset blanks all displays and sets the display count
// to four. The configuration channel is always ready.
module seven_segment_number_formatter #(
    parameter int MAX_DISPLAYS    = ssnf_pkg::MAX_DISPLAYS_DEF,
    parameter int FRACTION_DIGITS = ssnf_pkg::FRACTION_DIGITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Input item stream.
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [8*ssnf_pkg::VALUE_BYTES-1:0]      s_tdata,  // [49:0] value, rest zero
    input  logic [0:0]                              s_tuser,  // [0] mode
    // Result stream.
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [ssnf_pkg::OUT_DATA_W-1:0]         m_tdata,  // [63:0] segment_patterns,
                                                              // [71:64] updated_mask
    output logic [0:0]                              m_tuser,  // [0] overflow
    // Configuration write channel.
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [ssnf_pkg::COUNT_W-1:0]            cfg_data  // display_count
);
    import ssnf_pkg::*;

    ssnf_state_t                     state_reg, state_next;
    logic                            mode_reg, mode_next;
    logic [COUNT_W-1:0]              dcount_reg;
    logic [COUNT_W:0]                digits_reg, digits_next;
    pattern_t [MAX_DISPLAYS-1:0]     pat_reg, pat_next;
    logic [OUT_DATA_W-1:0]           out_data_reg, out_data_next;
    logic                            out_ovf_reg, out_ovf_next;

    logic                            bcd_start;
    logic                            bcd_done;
    bcd_word_t                       bcd;

    // Active display count, saturated into 1..MAX_DISPLAYS.
    logic [COUNT_W-1:0]              dc;

    // Decode of the current item, used in the store update cycle.
    logic                            err;
    logic [COUNT_W-1:0]              frac;
    logic [COUNT_W-1:0]              frac_idx;
    logic                            use_frac;
    logic [COUNT_W-1:0]              base;
    logic [COUNT_W-1:0]              shown_cnt;
    pattern_t [MAX_DISPLAYS-1:0]     new_pat;
    logic [MAX_DISPLAYS-1:0]         wr_en;

    ssnf_bcd_conv u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bcd_start),
        .bin   (s_tdata[VALUE_W-1:0]),
        .done  (bcd_done),
        .bcd   (bcd)
    );

    always_comb
    begin
        if (dcount_reg == '0)
        begin
            dc = COUNT_W'(1);
        end
        else if (dcount_reg > COUNT_W'(MAX_DISPLAYS))
        begin
            dc = COUNT_W'(MAX_DISPLAYS);
        end
        else
        begin
            dc = dcount_reg;
        end
    end

    // The integer part is counted as at least one digit: the highest nonzero
    // BCD digit at or above the ones position sets the count.
    always_comb
    begin
        digits_next = (COUNT_W+1)'(1);
        for (int k = FRACTION_DIGITS; k < BCD_DIGITS; k++)
        begin
            if (bcd[k] != '0)
            begin
                digits_next = (COUNT_W+1)'(k - FRACTION_DIGITS + 1);
            end
        end
    end

    // When the displays left over after the integer part reach into the stored
    // fraction and the last fractional digit that fits is nonzero, the window
    // slides down so that the whole row is filled and the point lands on the
    // ones digit.
    always_comb
    begin
        err       = digits_reg > {1'b0, dc};
        frac      = dc - digits_reg[COUNT_W-1:0];
        frac_idx  = COUNT_W'(FRACTION_DIGITS) - frac;
        use_frac  = !err && (frac != '0) && (frac <= COUNT_W'(FRACTION_DIGITS))
                    && (bcd[frac_idx] != '0);
        base      = use_frac ? frac_idx : COUNT_W'(FRACTION_DIGITS);
        shown_cnt = use_frac ? dc : digits_reg[COUNT_W-1:0];

        for (int i = 0; i < MAX_DISPLAYS; i++)
        begin
            new_pat[i] = '0;
            wr_en[i]   = 1'b0;
            if (mode_reg == MODE_CLEAR)
            begin
                wr_en[i] = COUNT_W'(i) < dc;
            end
            else if (err)
            begin
                // The error text sits on the top active displays.
                if (COUNT_W'(i + 1) == dc)
                begin
                    new_pat[i] = SEG_E;
                    wr_en[i]   = 1'b1;
                end
                else if (COUNT_W'(i + 2) == dc || COUNT_W'(i + 3) == dc)
                begin
                    new_pat[i] = SEG_R;
                    wr_en[i]   = 1'b1;
                end
            end
            else if (COUNT_W'(i) < shown_cnt)
            begin
                new_pat[i] = glyph(bcd[base + COUNT_W'(i)]);
                if (use_frac && COUNT_W'(i) == frac)
                begin
                    new_pat[i] = new_pat[i] ^ SEG_DP;
                end
                wr_en[i] = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        pat_next      = pat_reg;
        out_data_next = out_data_reg;
        out_ovf_next  = out_ovf_reg;
        bcd_start     = 1'b0;
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    mode_next = s_tuser[0];
                    if (s_tuser[0] == MODE_CLEAR)
                    begin
                        state_next = ST_APPLY;
                    end
                    else
                    begin
                        bcd_start  = 1'b1;
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                if (bcd_done)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                for (int i = 0; i < MAX_DISPLAYS; i++)
                begin
                    if (wr_en[i])
                    begin
                        pat_next[i] = new_pat[i];
                    end
                end
                out_data_next = '0;
                for (int i = 0; i < MAX_DISPLAYS; i++)
                begin
                    out_data_next[8*i +: 8]          = pat_next[i];
                    out_data_next[PATTERNS_W + i]    = wr_en[i];
                end
                out_ovf_next = (mode_reg == MODE_SHOW) && err;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mode_reg   <= MODE_SHOW;
            pat_reg    <= '0;
            dcount_reg <= DISPLAY_COUNT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            pat_reg   <= pat_next;
            if (cfg_valid && cfg_ready)
            begin
                dcount_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg   <= (state_reg == ST_COUNT) ? digits_next : digits_reg;
        out_data_reg <= out_data_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign cfg_ready  = 1'b1;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_ovf_reg;

endmodule

// ===== hdl/ssnf_checker.sv =====
// Port-level checks for the seven-segment number formatter, bound to the top
// level. Depends on ssnf_pkg for port widths.
module ssnf_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [ssnf_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic [0:0]                          m_tuser
);
    import ssnf_pkg::*;

    // One transaction at a time: no new input while a result is pending.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted transaction");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Every transaction rewrites at least one display.
    a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:PATTERNS_W] != '0)
        else $error("result with empty update mask");

    // The error text covers at most three displays.
    a_error_width: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> $countones(m_tdata[OUT_DATA_W-1:PATTERNS_W]) <= 3)
        else $error("overflow result rewrote too many displays");

endmodule

bind seven_segment_number_formatter ssnf_checker u_ssnf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== bench/tb_seven_segment_number_formatter.sv =====
// Self-checking testbench for seven_segment_number_formatter: drives value and clear
// transactions, predicts the digit store and compares every result transaction.
// Depends on ssnf_pkg and the formatter RTL; needs nothing else.
`timescale 1ns / 100ps

module tb_seven_segment_number_formatter;

    import ssnf_pkg::*;

    localparam int SETTLE_CYCLES = 60;    // idle margin before the final report
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int PHASE_ITEMS   = 150;
    localparam int RANDOM_PHASES = 12;
    localparam int PRINT_LIMIT   = 100;

    // One input item as the block sees it.
    typedef struct packed {
        logic                 mode;
        logic [VALUE_W-1:0]   value;
    } disp_item_t;

    // One result transaction: the whole display row, what changed, and the error flag.
    typedef struct packed {
        logic [PATTERNS_W-1:0] patterns;
        logic [MASK_W-1:0]     mask;
        logic                  overflow;
    } disp_frame_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [8*VALUE_BYTES-1:0]   s_tdata = '0;
    logic [0:0]                 s_tuser = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]      m_tdata;
    logic [0:0]                 m_tuser;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [COUNT_W-1:0]         cfg_data = '0;

    // Segment glyphs of the digits 0 to 9, lit bits in HGFEDCBA order.
    pattern_t digit_glyph [10] = '{8'd63, 8'd6, 8'd91, 8'd79, 8'd102,
                                   8'd109, 8'd125, 8'd7, 8'd127, 8'd111};

    // Testbench copy of the block's state and its display count register.
    pattern_t           digit_store [MAX_DISPLAYS_DEF];
    logic [COUNT_W-1:0] shown_count = DISPLAY_COUNT_RESET;

    disp_item_t  pending_items [$];
    disp_frame_t expected_frames [$];

    int  in_offered    = 0;
    int  in_accepted   = 0;
    int  error_count   = 0;
    int  send_gap      = 0;
    int  ready_gap     = 0;
    int  hold_left     = 0;
    bit  hold_req      = 1'b0;
    bit  gaps_on       = 1'b1;

    seven_segment_number_formatter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        for (int k = 0; k < MAX_DISPLAYS_DEF; k++)
        begin
            digit_store[k] = '0;
        end
    end

    function automatic longint unsigned pow_ten(input int n);
        longint unsigned p;
        p = 1;
        for (int k = 0; k < n; k++)
        begin
            p = p * 10;
        end
        return p;
    endfunction

    // Applies one item to the digit store copy and returns the result it must give.
    function automatic disp_frame_t format_number(input disp_item_t item);
        disp_frame_t     r;
        longint unsigned whole;
        longint unsigned shown;
        longint unsigned scaled;
        int              dc;
        int              digits;
        int              frac;
        int              dp_pos;
        pattern_t        pat;

        r = '0;
        dc = int'(shown_count);
        if (dc < 1)
            dc = 1;
        if (dc > MAX_DISPLAYS_DEF)
            dc = MAX_DISPLAYS_DEF;

        if (item.mode == MODE_CLEAR)
        begin
            for (int i = 0; i < dc; i++)
            begin
                digit_store[i] = '0;
                r.mask[i] = 1'b1;
            end
        end
        else
        begin
            whole = longint'(item.value) / pow_ten(FRACTION_DIGITS_DEF);
            digits = 1;
            shown = whole;
            while (shown >= 10)
            begin
                shown = shown / 10;
                digits++;
            end
            if (digits > dc)
            begin
                // Integer part too long: "Err" from the top display down, as far as it fits.
                r.overflow = 1'b1;
                digit_store[dc-1] = SEG_E;
                r.mask[dc-1] = 1'b1;
                if (dc >= 2)
                begin
                    digit_store[dc-2] = SEG_R;
                    r.mask[dc-2] = 1'b1;
                end
                if (dc >= 3)
                begin
                    digit_store[dc-3] = SEG_R;
                    r.mask[dc-3] = 1'b1;
                end
            end
            else
            begin
                shown = whole;
                frac = dc - digits;
                dp_pos = 0;
                if (frac > 0 && frac <= FRACTION_DIGITS_DEF)
                begin
                    // Fraction shown only when its last visible digit is nonzero.
                    scaled = longint'(item.value) / pow_ten(FRACTION_DIGITS_DEF - frac);
                    if (scaled % 10 != 0)
                    begin
                        shown = scaled;
                        dp_pos = frac;
                        digits = digits + frac;
                    end
                end
                for (int i = 0; i < digits && i < MAX_DISPLAYS_DEF; i++)
                begin
                    pat = digit_glyph[int'(shown % 10)];
                    if (dp_pos != 0 && dp_pos == i)
                        pat = pat ^ SEG_DP;
                    digit_store[i] = pat;
                    r.mask[i] = 1'b1;
                    shown = shown / 10;
                end
            end
        end

        for (int i = 0; i < MAX_DISPLAYS_DEF; i++)
        begin
            r.patterns[8*i +: 8] = digit_store[i];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Sender: holds an offered item until its transaction completes, otherwise takes
    // the next pending item or inserts an idle burst.
    always @(negedge clk)
    begin
        if (!(s_tvalid && in_accepted != in_offered))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (rst_n && pending_items.size() != 0)
            begin
                if (gaps_on && $urandom_range(0, 3) == 0)
                begin
                    send_gap = $urandom_range(1, 14) - 1;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    s_tdata <= {{(8*VALUE_BYTES-VALUE_W){1'b0}}, pending_items[0].value};
                    s_tuser <= pending_items[0].mode;
                    s_tvalid <= 1'b1;
                    void'(pending_items.pop_front());
                    in_offered++;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long hold-off of the receiver, counted here so the ready driver only looks at it.
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: random stall bursts on top of the long hold-off.
    always @(negedge clk)
    begin
        if (ready_gap > 0)
        begin
            ready_gap--;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_tready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            ready_gap = $urandom_range(1, 14) - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Input monitor: every accepted item updates the prediction.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_frames.push_back(
                format_number(disp_item_t'{s_tuser[0], s_tdata[VALUE_W-1:0]}));
            in_accepted++;
        end
    end

    // Output monitor: each result transaction against the oldest prediction.
    always @(posedge clk)
    begin
        disp_frame_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_frames.size() == 0)
            begin
                report_mismatch("unexpected result", m_tdata[63:0], '0);
            end
            else
            begin
                want = expected_frames.pop_front();
                if (m_tdata[PATTERNS_W-1:0] !== want.patterns)
                    report_mismatch("segment_patterns", m_tdata[PATTERNS_W-1:0], want.patterns);
                if (m_tdata[PATTERNS_W +: MASK_W] !== want.mask)
                    report_mismatch("updated_mask", m_tdata[PATTERNS_W +: MASK_W], want.mask);
                if (m_tuser[0] !== want.overflow)
                    report_mismatch("overflow", m_tuser[0], want.overflow);
            end
        end
    end

    // Waits until every item went through and every result was taken.
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_offered != in_accepted
               || expected_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_display_count(input logic [COUNT_W-1:0] count);
        @(negedge clk);
        cfg_data <= count;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        shown_count = count;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_show(input logic [VALUE_W-1:0] v);
        pending_items.push_back(disp_item_t'{MODE_SHOW, v});
    endtask

    task automatic push_clear();
        pending_items.push_back(disp_item_t'{MODE_CLEAR, VALUE_W'($urandom)});
    endtask

    // Mostly well-formed numbers whose integer length lands near the display count,
    // with some raw 50-bit noise and clear commands.
    function automatic disp_item_t random_item();
        disp_item_t      it;
        int              sel;
        int              n;
        int              k;
        longint unsigned whole;
        longint unsigned frac;

        sel = $urandom_range(0, 99);
        it.mode = MODE_SHOW;
        if (sel < 10)
        begin
            it.mode = MODE_CLEAR;
            it.value = VALUE_W'({$urandom, $urandom});
        end
        else if (sel < 25)
        begin
            it.value = VALUE_W'({$urandom, $urandom});
        end
        else
        begin
            n = $urandom_range(0, 9);
            if (n == 0)
                whole = 0;
            else if (n == 9)
                whole = $urandom_range(112589989, 100000000);
            else
                whole = $urandom_range(int'(pow_ten(n)) - 1, int'(pow_ten(n - 1)));
            frac = $urandom_range(9999999, 0);
            k = $urandom_range(0, 7);
            frac = (frac / pow_ten(k)) * pow_ten(k);
            it.value = VALUE_W'(whole * pow_ten(FRACTION_DIGITS_DEF) + frac);
        end
        return it;
    endfunction

    initial
    begin
        logic [COUNT_W-1:0] count;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed part at the reset display count of four.
        push_show(50'd0);                       // integer part zero shows a single 0
        push_show(50'd12340000);                // 1.234 fills the row
        push_show(50'd12300000);                // last visible digit zero: integer only
        push_show(50'd50000);                   // 0.005
        push_show(50'd1);                       // fraction below the visible digits
        push_show(50'd99990000000);             // four digits exactly
        push_clear();
        push_show(50'd100000000000);            // one digit too many
        push_show({VALUE_W{1'b1}});             // largest value
        wait_drained();

        write_display_count(4'd8);
        push_show(50'd5);                       // 0.0000005 on all eight displays
        push_show(50'd12345678);                // 1.2345678
        push_show(50'd123456780000000);         // eight integer digits
        push_show(50'd1000000000000000);        // nine integer digits
        push_clear();
        wait_drained();

        // Short rows: the error text is cut to the displays that exist.
        write_display_count(4'd1);
        push_show(50'd100000000);
        push_show(50'd75000000);
        push_clear();
        wait_drained();

        write_display_count(4'd2);
        push_show(50'd1000000000);
        push_show(50'd34000000);
        wait_drained();

        write_display_count(4'd3);
        push_show(50'd10000000000);
        wait_drained();

        // Out-of-range counts saturate to one and to eight.
        write_display_count(4'd0);
        push_show(50'd1230000000);
        push_show(50'd90000000);
        wait_drained();

        write_display_count(4'd15);
        push_show({VALUE_W{1'b1}});
        push_show(50'd50000000);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            unique case (phase)
                0:       count = 4'd8;
                1:       count = 4'd1;
                2:       count = 4'd15;
                3:       count = 4'd0;
                4:       count = 4'd2;
                5:       count = 4'd4;
                default: count = COUNT_W'($urandom_range(0, 15));
            endcase
            write_display_count(count);
            if (phase == RANDOM_PHASES - 1)
                gaps_on = 1'b0;
            else
                gaps_on = ($urandom_range(0, 3) != 0);
            // The receiver stops for a long stretch while the sender keeps offering.
            if (phase == 1 || phase == 6)
                hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                pending_items.push_back(random_item());
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog, several times the slowest correct run.
    initial
    begin
        #15000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
